// File: design/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg: shared definitions for the motor serial link framer
// Command kinds, frame byte constants, sequencer states and the control
// group that drives the shared XOR unit.
// ----------------------------------------------------------------------------
package msl_pkg;

  typedef enum logic [2:0] {
    KIND_ENABLE   = 3'd0,
    KIND_SET_MODE = 3'd1,
    KIND_SET_SPD  = 3'd2,
    KIND_SET_TGT  = 3'd3,
    KIND_ADD_TGT  = 3'd4,
    KIND_SEND_TGT = 3'd5,
    KIND_REQ_POS  = 3'd6,
    KIND_RX_BYTE  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_CHECK,
    ST_REPORT
  } state_e;

  localparam logic [7:0] FRAME_HDR = 8'h7A;
  localparam logic [7:0] FRAME_TLR = 8'h7B;
  localparam logic [7:0] CMD_MODE  = 8'h00;
  localparam logic [7:0] CMD_SPEED = 8'h01;
  localparam logic [7:0] CMD_TGT   = 8'h02;
  localparam logic [7:0] CMD_EN    = 8'h06;
  localparam logic [7:0] CMD_POS   = 8'h0E;
  localparam logic [7:0] POS_ARG   = 8'h01;
  localparam logic [7:0] REPLY_POS = 8'h01;

  localparam int unsigned REPLY_BYTES = 9;
  localparam int unsigned FRAME_BUF   = 7;

  // Control group for the shared XOR accumulator.
  typedef struct packed {
    logic clr;
    logic en;
  } xor_ctrl_t;

endpackage

// File: design/motor_serial_link_framer.sv
// ----------------------------------------------------------------------------
// motor_serial_link_framer: servo link command framer and reply deframer
// Builds command frames byte by byte and checks a sliding window of
// received bytes for a valid position reply.
// ----------------------------------------------------------------------------
// Usage
//   The input channel (in_valid_i / in_ready_o) carries one command or one
//   received link byte per transfer. The output channel (out_valid_o /
//   out_ready_i) carries one frame byte or one position report per transfer.
//   A small sequencer walks each item through a single shared XOR unit.
//   A framed command of N bytes (5, 6, 7 or 9) is taken in by one input
//   transfer and then sent one frame byte per cycle while the receiver does
//   not stall.
//   Set target and add target produce nothing and leave the block ready.
//   A received byte is handled in steps: the transfer, an XOR pass over the
//   first seven window bytes, then the compare; a valid reply adds a report step.
//   The block is not ready for a new item until the current one is done.
//   The output register holds its contents while out_ready_i is low and the
//   emit and report steps simply wait, so a stall lengthens an item by the stall time.
//   Reset clears the motor id, target, latched position, feedback flag and
//   the receive window to zero; no clearing pass is needed.
//   The motor id may be written through cfg_we_i only while the block idles.
// ----------------------------------------------------------------------------
module motor_serial_link_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [15:0]        mode_value_i,
  input  logic signed [15:0] speed_value_i,
  input  logic signed [31:0] position_value_i,
  input  logic [7:0]         rx_byte_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_report_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o,
  output logic signed [31:0] position_now_o,
  output logic               feedback_seen_o
);
  import msl_pkg::*;

  // Architectural state.
  logic [7:0]  motor_id_q;
  logic [31:0] target_q;
  logic [31:0] cur_pos_q;
  logic        fb_seen_q;
  logic [7:0]  win_q [REPLY_BYTES];

  // Sequencer state.
  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  body_q;
  logic [7:0]  frame_q [FRAME_BUF];

  // Output register.
  logic        out_valid_q;
  logic        is_report_q;
  logic [7:0]  tx_byte_q;
  logic        last_q;
  logic [31:0] pos_out_q;
  logic        fb_out_q;

  kind_e       kind;
  logic        in_fire;
  logic        slot_free;
  logic        emit_last;
  logic        emit_body;
  logic        check_done;
  logic        reply_ok;
  logic        load_out;
  logic [7:0]  emit_byte;
  logic [7:0]  win_byte;
  logic [7:0]  xor_acc;
  xor_ctrl_t   xor_ctrl;
  logic [7:0]  xor_byte;

  assign kind       = kind_e'(kind_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit_body  = cnt_q < {1'b0, body_q};
  assign emit_last  = cnt_q == ({1'b0, body_q} + 4'd1);
  assign check_done = cnt_q == 4'd7;

  // Frame byte at the current position: stored body, then the check, then
  // the tail.
  always_comb begin
    if (emit_body) begin
      emit_byte = frame_q[cnt_q[2:0]];
    end else if (cnt_q == {1'b0, body_q}) begin
      emit_byte = xor_acc;
    end else begin
      emit_byte = FRAME_TLR;
    end
  end

  assign win_byte = win_q[cnt_q];

  // A reply is valid when the framing, address, command and check all agree.
  // The XOR over the first seven window bytes is complete once the count
  // reaches seven.
  assign reply_ok = (win_q[0] == FRAME_HDR) && (win_q[REPLY_BYTES-1] == FRAME_TLR) &&
                    (win_q[1] == motor_id_q) && (win_q[2] == REPLY_POS) &&
                    (win_q[REPLY_BYTES-2] == xor_acc);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (kind == KIND_SET_TGT || kind == KIND_ADD_TGT) begin
            state_d = ST_IDLE;
          end else if (kind == KIND_RX_BYTE) begin
            state_d = ST_CHECK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (check_done) begin
          state_d = reply_ok ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    xor_ctrl.clr = 1'b0;
    xor_ctrl.en  = 1'b0;
    xor_byte     = emit_byte;
    load_out     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        xor_ctrl.clr = in_fire;
      end
      ST_EMIT: begin
        xor_ctrl.en = slot_free && emit_body;
        load_out    = slot_free;
      end
      ST_CHECK: begin
        xor_ctrl.en = !check_done;
        xor_byte    = win_byte;
      end
      ST_REPORT: begin
        load_out = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Byte counter.
  always_comb begin
    cnt_d = cnt_q;
    if (in_fire) begin
      cnt_d = 4'd0;
    end else if ((state_q == ST_EMIT && slot_free) ||
                 (state_q == ST_CHECK && !check_done)) begin
      cnt_d = cnt_q + 4'd1;
    end
  end

  msl_xor_unit u_xor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (xor_ctrl),
    .byte_i (xor_byte),
    .acc_o  (xor_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      motor_id_q  <= 8'h00;
      target_q    <= 32'd0;
      cur_pos_q   <= 32'd0;
      fb_seen_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < REPLY_BYTES; i++) begin
        win_q[i] <= 8'h00;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        motor_id_q <= cfg_wdata_i;
      end
      if (in_fire && kind == KIND_SET_TGT) begin
        target_q <= position_value_i;
      end else if (in_fire && kind == KIND_ADD_TGT) begin
        target_q <= target_q + position_value_i;
      end
      // Received bytes slide through the window; only reset clears it.
      if (in_fire && kind == KIND_RX_BYTE) begin
        for (int i = 0; i < REPLY_BYTES - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[REPLY_BYTES-1] <= rx_byte_i;
      end
      if (state_q == ST_CHECK && check_done && reply_ok) begin
        cur_pos_q <= {win_q[3], win_q[4], win_q[5], win_q[6]};
        fb_seen_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame body and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q[0] <= FRAME_HDR;
      frame_q[1] <= motor_id_q;
      frame_q[2] <= CMD_EN;
      frame_q[3] <= 8'h00;
      frame_q[4] <= 8'h00;
      frame_q[5] <= 8'h00;
      frame_q[6] <= 8'h00;
      body_q     <= 3'd3;
      unique case (kind)
        KIND_ENABLE: begin
          frame_q[2] <= CMD_EN;
          body_q     <= 3'd3;
        end
        KIND_SET_MODE: begin
          frame_q[2] <= CMD_MODE;
          frame_q[3] <= mode_value_i[15:8];
          frame_q[4] <= mode_value_i[7:0];
          body_q     <= 3'd5;
        end
        KIND_SET_SPD: begin
          frame_q[2] <= CMD_SPEED;
          frame_q[3] <= speed_value_i[15:8];
          frame_q[4] <= speed_value_i[7:0];
          body_q     <= 3'd5;
        end
        KIND_SEND_TGT: begin
          frame_q[2] <= CMD_TGT;
          frame_q[3] <= target_q[31:24];
          frame_q[4] <= target_q[23:16];
          frame_q[5] <= target_q[15:8];
          frame_q[6] <= target_q[7:0];
          body_q     <= 3'd7;
        end
        KIND_REQ_POS: begin
          frame_q[2] <= CMD_POS;
          frame_q[3] <= POS_ARG;
          body_q     <= 3'd4;
        end
        KIND_SET_TGT, KIND_ADD_TGT, KIND_RX_BYTE: begin
          body_q <= 3'd3;
        end
        default: begin
          body_q <= 3'd3;
        end
      endcase
    end
    if (load_out) begin
      is_report_q <= (state_q == ST_REPORT);
      tx_byte_q   <= (state_q == ST_REPORT) ? 8'h00 : emit_byte;
      last_q      <= (state_q == ST_REPORT) || emit_last;
      pos_out_q   <= cur_pos_q;
      fb_out_q    <= fb_seen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_report_o     = is_report_q;
  assign tx_byte_o       = tx_byte_q;
  assign last_byte_o     = last_q;
  assign position_now_o  = pos_out_q;
  assign feedback_seen_o = fb_out_q;

  // A command that produces bytes, or a received byte, keeps the block busy.
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i != KIND_SET_TGT && kind_i != KIND_ADD_TGT)
      |=> !in_ready_o)
    else $error("block ready directly after a result-producing transfer");

  // A report always closes its item, carries a zero byte and a set flag.
  a_report_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_report_o) |-> (last_byte_o && tx_byte_o == 8'h00 && feedback_seen_o))
    else $error("malformed position report");

  // The output is only loaded while the sequencer is emitting or reporting.
  a_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == ST_EMIT || state_q == ST_REPORT))
    else $error("output loaded outside an emit or report step");

  // The last frame byte is always the tail.
  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_report_o && last_byte_o) |-> (tx_byte_o == FRAME_TLR))
    else $error("last frame byte is not the tail");

endmodule

// File: design/msl_xor_unit.sv
// ----------------------------------------------------------------------------
// msl_xor_unit: shared XOR check accumulator
// Folds one byte a cycle, while enabled, into a running check value; used both to build
// the check byte of outgoing frames and to verify received replies.
// ----------------------------------------------------------------------------
module msl_xor_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msl_pkg::xor_ctrl_t ctrl_i,
  input  logic [7:0]        byte_i,
  output logic [7:0]        acc_o
);
  import msl_pkg::*;

  logic [7:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = 8'h00;
    end else if (ctrl_i.en) begin
      acc_d = acc_q ^ byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: bench/msl_link_checker.sv
// ----------------------------------------------------------------------------
// msl_link_checker: predicts and checks the motor serial link framer
// Watches the configuration port and both channels, works out the frame
// bytes and position reports that each input transfer must produce, and
// compares every output transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module msl_link_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         kind_i,
  input  logic [15:0]        mode_value_i,
  input  logic signed [15:0] speed_value_i,
  input  logic signed [31:0] position_value_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               is_report_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               last_byte_i,
  input  logic signed [31:0] position_now_i,
  input  logic               feedback_seen_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);
  import msl_pkg::*;

  localparam int unsigned MAX_FRAME = 9;

  typedef struct packed {
    logic        is_report;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic [31:0] position_now;
    logic        feedback_seen;
  } link_result_t;

  link_result_t due_results[$];
  logic [7:0]   motor_id;
  logic [31:0]  target_pos;
  logic [31:0]  latched_pos;
  logic         feedback_flag;
  logic [7:0]   rx_window [REPLY_BYTES];
  int unsigned  mismatches = 0;

  assign mismatches_o = mismatches;

  // Every result carries the feedback state as it stands when it is predicted.
  function automatic link_result_t snapshot(input logic rep, input logic [7:0] tx,
                                            input logic last);
    link_result_t r;
    r.is_report     = rep;
    r.tx_byte       = tx;
    r.last_byte     = last;
    r.position_now  = latched_pos;
    r.feedback_seen = feedback_flag;
    return r;
  endfunction

  // Header, motor id, code and big-endian payload, then XOR check and tail.
  task automatic queue_frame(input logic [7:0] code, input logic [31:0] payload,
                             input int unsigned payload_bytes);
    logic [7:0]  frame [MAX_FRAME];
    int unsigned body;
    int unsigned i;
    body     = 3 + payload_bytes;
    frame[0] = FRAME_HDR;
    frame[1] = motor_id;
    frame[2] = code;
    for (i = 0; i < payload_bytes; i++)
      frame[3 + i] = 8'(payload >> (8 * (payload_bytes - 1 - i)));
    frame[body] = 8'h00;
    for (i = 0; i < body; i++)
      frame[body] ^= frame[i];
    frame[body + 1] = FRAME_TLR;
    for (i = 0; i <= body + 1; i++)
      due_results.push_back(snapshot(1'b0, frame[i], i == body + 1));
  endtask

  // The window slides on every received byte and is cleared only at reset.
  task automatic take_rx_byte(input logic [7:0] rx);
    logic [7:0]  chk;
    int unsigned i;
    for (i = 0; i < REPLY_BYTES - 1; i++)
      rx_window[i] = rx_window[i + 1];
    rx_window[REPLY_BYTES - 1] = rx;
    chk = 8'h00;
    for (i = 0; i < REPLY_BYTES - 2; i++)
      chk ^= rx_window[i];
    if (rx_window[0] == FRAME_HDR && rx_window[REPLY_BYTES - 1] == FRAME_TLR &&
        rx_window[1] == motor_id && rx_window[2] == REPLY_POS &&
        rx_window[REPLY_BYTES - 2] == chk) begin
      latched_pos   = {rx_window[3], rx_window[4], rx_window[5], rx_window[6]};
      feedback_flag = 1'b1;
      due_results.push_back(snapshot(1'b1, 8'h00, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t want;
    int unsigned  i;
    if (!rst_ni) begin
      motor_id      = 8'h00;
      target_pos    = '0;
      latched_pos   = '0;
      feedback_flag = 1'b0;
      for (i = 0; i < REPLY_BYTES; i++)
        rx_window[i] = 8'h00;
      due_results.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing outstanding: is_report %0b, tx_byte %0h",
                 is_report_i, tx_byte_i);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("is_report", 32'(want.is_report), 32'(is_report_i));
          check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte_i));
          check_field("last_byte", 32'(want.last_byte), 32'(last_byte_i));
          check_field("position_now", want.position_now, position_now_i);
          check_field("feedback_seen", 32'(want.feedback_seen), 32'(feedback_seen_i));
        end
      end
      if (cfg_we_i)
        motor_id = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        case (kind_e'(kind_i))
          KIND_ENABLE:   queue_frame(CMD_EN, 32'h0, 0);
          KIND_SET_MODE: queue_frame(CMD_MODE, {16'h0, mode_value_i}, 2);
          KIND_SET_SPD:  queue_frame(CMD_SPEED, {16'h0, speed_value_i}, 2);
          KIND_SET_TGT:  target_pos = position_value_i;
          KIND_ADD_TGT:  target_pos = target_pos + position_value_i;
          KIND_SEND_TGT: queue_frame(CMD_TGT, target_pos, 4);
          KIND_REQ_POS:  queue_frame(CMD_POS, {24'h0, POS_ARG}, 1);
          default:       take_rx_byte(rx_byte_i);
        endcase
      end
      outstanding_o <= due_results.size();
    end
  end

endmodule

// File: bench/motor_serial_link_framer_tb.sv
// ----------------------------------------------------------------------------
// motor_serial_link_framer_tb: stimulus and verdict for the link framer
// Drives a directed opening sequence and then random commands, position
// replies (mostly well formed, some deliberately damaged) and noise bytes
// under several motor ids, with random gaps on both channels. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module motor_serial_link_framer_tb;
  import msl_pkg::*;

  // The slowest item is a nine-byte frame; even with heavy stalls on the
  // output side a few hundred items finish far below this bound.
  localparam int unsigned MAX_CYCLES    = 400_000;
  // A received byte that completes no reply still keeps the block busy through
  // its XOR pass and compare, so this many cycles are let pass before a register
  // write and before the verdict.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam int unsigned IDLE_PERCENT  = 29;

  // Ways in which a generated position reply may be damaged.
  typedef enum {
    FLAW_NONE,
    FLAW_ID,
    FLAW_CODE,
    FLAW_CHECK,
    FLAW_FRAME,
    FLAW_SHORT
  } reply_flaw_e;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [7:0]         cfg_wdata      = 8'h00;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [2:0]         kind           = KIND_ENABLE;
  logic [15:0]        mode_value     = '0;
  logic signed [15:0] speed_value    = '0;
  logic signed [31:0] position_value = '0;
  logic [7:0]         rx_byte        = 8'h00;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               is_report;
  logic [7:0]         tx_byte;
  logic               last_byte;
  logic signed [31:0] position_now;
  logic               feedback_seen;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  logic [7:0]  link_id    = 8'h00;
  // While set, neither side inserts gaps: a long stretch at full rate.
  logic        calm       = 1'b0;

  motor_serial_link_framer DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .kind_i          (kind),
    .mode_value_i    (mode_value),
    .speed_value_i   (speed_value),
    .position_value_i(position_value),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .is_report_o     (is_report),
    .tx_byte_o       (tx_byte),
    .last_byte_o     (last_byte),
    .position_now_o  (position_now),
    .feedback_seen_o (feedback_seen)
  );

  msl_link_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .kind_i          (kind),
    .mode_value_i    (mode_value),
    .speed_value_i   (speed_value),
    .position_value_i(position_value),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .is_report_i     (is_report),
    .tx_byte_i       (tx_byte),
    .last_byte_i     (last_byte),
    .position_now_i  (position_now),
    .feedback_seen_i (feedback_seen),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random, except during the calm stretch.
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one item and returns at the edge at which it is transferred.
  // Valid is only lowered when a gap is actually inserted, so it is never
  // dropped and raised again within one time step.
  task automatic push_item(input kind_e k, input logic [15:0] mode,
                           input logic [15:0] speed, input logic [31:0] pos,
                           input logic [7:0] rx);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    mode_value     <= mode;
    speed_value    <= speed;
    position_value <= pos;
    rx_byte        <= rx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // The motor id may only change once the block has gone quiet: every
  // expected result has arrived and any trailing received byte is done.
  task automatic set_motor_id(input logic [7:0] id);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we    <= 1'b0;
    link_id    = id;
  endtask

  // Positions lean towards the signed and unsigned extremes.
  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Sends a position reply byte by byte as received link bytes. A damaged
  // reply has a wrong id or code (with a consistent check byte), a bad check
  // byte, a bad header or tail, or is cut short.
  task automatic send_reply(input logic [7:0] id, input logic [31:0] pos,
                            input reply_flaw_e flaw);
    logic [7:0]  reply [REPLY_BYTES];
    int unsigned count;
    int unsigned spot;
    int unsigned i;
    reply[0] = FRAME_HDR;
    reply[1] = (flaw == FLAW_ID) ? id ^ 8'($urandom_range(1, 255)) : id;
    reply[2] = (flaw == FLAW_CODE) ? REPLY_POS ^ 8'($urandom_range(1, 255)) : REPLY_POS;
    {reply[3], reply[4], reply[5], reply[6]} = pos;
    reply[REPLY_BYTES - 2] = 8'h00;
    for (i = 0; i < REPLY_BYTES - 2; i++)
      reply[REPLY_BYTES - 2] ^= reply[i];
    reply[REPLY_BYTES - 1] = FRAME_TLR;
    if (flaw == FLAW_CHECK)
      reply[REPLY_BYTES - 2] ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_FRAME) begin
      spot = $urandom_range(0, 1) ? REPLY_BYTES - 1 : 0;
      reply[spot] ^= 8'($urandom_range(1, 255));
    end
    count = (flaw == FLAW_SHORT) ? $urandom_range(1, REPLY_BYTES - 1) : REPLY_BYTES;
    for (i = 0; i < count; i++)
      push_item(KIND_RX_BYTE, 16'($urandom), 16'($urandom), $urandom, reply[i]);
  endtask

  // One random step: mostly well-formed replies and commands, some noise.
  task automatic random_step();
    int unsigned pick;
    reply_flaw_e flaw;
    kind_e       k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      flaw = FLAW_NONE;
      if ($urandom_range(0, 3) == 0)
        flaw = reply_flaw_e'($urandom_range(FLAW_ID, FLAW_SHORT));
      send_reply(link_id, pick_position(), flaw);
    end else if (pick < 85) begin
      k = kind_e'($urandom_range(KIND_ENABLE, KIND_REQ_POS));
      push_item(k, 16'($urandom), 16'($urandom), pick_position(), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3))
        push_item(KIND_RX_BYTE, 16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0]  phase_ids [5];
    int unsigned goal;
    int unsigned p;
    // Motor ids per phase: both extremes, the header and tail codes, and
    // one random value.
    phase_ids    = '{8'h00, 8'h7A, 8'h00, 8'h7B, 8'hFF};
    phase_ids[2] = 8'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the all-ones motor id. Fields that a command
    // does not use carry random values and must be ignored.
    set_motor_id(8'hFF);
    push_item(KIND_ENABLE,   16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    push_item(KIND_SET_MODE, 16'h0000, 16'($urandom), $urandom, 8'($urandom));
    push_item(KIND_SET_MODE, 16'hFFFF, 16'($urandom), $urandom, 8'($urandom));
    push_item(KIND_SET_SPD,  16'($urandom), 16'h8000, $urandom, 8'($urandom));
    push_item(KIND_SET_SPD,  16'($urandom), 16'h7FFF, $urandom, 8'($urandom));
    // The target crosses the signed boundary, then wraps through zero.
    push_item(KIND_SET_TGT,  16'($urandom), 16'($urandom), 32'h7FFF_FFFF, 8'($urandom));
    push_item(KIND_ADD_TGT,  16'($urandom), 16'($urandom), 32'h0000_0001, 8'($urandom));
    push_item(KIND_SEND_TGT, 16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    push_item(KIND_SET_TGT,  16'($urandom), 16'($urandom), 32'hFFFF_FFFF, 8'($urandom));
    push_item(KIND_ADD_TGT,  16'($urandom), 16'($urandom), 32'h0000_0001, 8'($urandom));
    push_item(KIND_SEND_TGT, 16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    push_item(KIND_ADD_TGT,  16'($urandom), 16'($urandom), 32'hFFFF_FFFF, 8'($urandom));
    push_item(KIND_SEND_TGT, 16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    // Position request before and after the first accepted reply, so the
    // feedback fields are seen in both states.
    push_item(KIND_REQ_POS,  16'($urandom), 16'($urandom), $urandom, 8'($urandom));
    send_reply(8'hFF, 32'h8000_0000, FLAW_NONE);
    push_item(KIND_REQ_POS,  16'($urandom), 16'($urandom), $urandom, 8'($urandom));

    // Random phases, each under its own motor id; the middle one runs with
    // no gaps on either side.
    for (p = 0; p < 5; p++) begin
      set_motor_id(phase_ids[p]);
      calm <= (p == 2);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal)
        random_step();
    end

    // Drain: wait for every outstanding result, then let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
design/msl_pkg.sv
design/msl_xor_unit.sv
design/motor_serial_link_framer.sv
bench/msl_link_checker.sv
bench/motor_serial_link_framer_tb.sv
